// File: hw/rtl/sbl_pkg.sv
// sbl_pkg: shared widths, reset values, register indexes and the queue flag type
// for the 3x3 sobel edge block; no dependencies
`timescale 1ns / 1ps

package sbl_pkg;

    localparam int SBL_MAX_WIDTH_DEF = 1024;

    localparam int SBL_PIX_W      = 8;
    localparam int SBL_GRAD_W     = 11;
    localparam int SBL_MAG_W      = 8;
    localparam int SBL_WIDTH_W    = 11;
    localparam int SBL_HEIGHT_W   = 12;
    localparam int SBL_CFG_IDX_W  = 1;
    localparam int SBL_CFG_DATA_W = 12;

    localparam logic [SBL_WIDTH_W-1:0]  SBL_WIDTH_RST  = 11'd640;
    localparam logic [SBL_HEIGHT_W-1:0] SBL_HEIGHT_RST = 12'd480;

    // configuration register indexes
    localparam logic [SBL_CFG_IDX_W-1:0] SBL_REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [SBL_CFG_IDX_W-1:0] SBL_REG_IMAGE_HEIGHT = 1'b1;

    // classification of one item, decided by the front end
    typedef struct packed {
        logic emit;  // interior pixel, gives a result
        logic last;  // result for the last interior pixel of the frame
    } t_sbl_flags;

endpackage

// File: hw/rtl/sbl_front.sv
// sbl_front: accepts pixels, converts to gray, tracks column/row position and
// classifies each item; depends on sbl_pkg
`timescale 1ns / 1ps

module sbl_front import sbl_pkg::*; #(
    parameter int MAX_WIDTH = SBL_MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [SBL_PIX_W-1:0]        i_red,
    input  logic [SBL_PIX_W-1:0]        i_green,
    input  logic [SBL_PIX_W-1:0]        i_blue,
    input  logic                        i_start_of_frame,
    input  logic [SBL_WIDTH_W-1:0]      i_image_width,
    input  logic [SBL_HEIGHT_W-1:0]     i_image_height,
    input  logic                        i_queue_full,
    output logic                        o_push,
    output logic [SBL_PIX_W-1:0]        o_gray,
    output logic [$clog2(MAX_WIDTH)-1:0] o_col,
    output t_sbl_flags                  o_flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > SBL_WIDTH_W) ? COL_W + 1 : SBL_WIDTH_W;

    logic [COL_W-1:0]        r_col, n_col;
    logic [SBL_HEIGHT_W-1:0] r_row, n_row;

    logic [COL_W-1:0]        col;
    logic [SBL_HEIGHT_W-1:0] row;
    logic [CMP_W-1:0]        col_x, width_x, max_x, w_eff;
    logic [SBL_HEIGHT_W-1:0] h_eff;
    logic [SBL_PIX_W+5-1:0]  gray_sum;
    logic                    row_end;

    assign o_push = i_valid && !i_queue_full;

    // gray = (11r + 16g + 5b) / 32
    assign gray_sum = 13'(i_red) * 13'd11 + 13'(i_green) * 13'd16 + 13'(i_blue) * 13'd5;
    assign o_gray   = gray_sum[SBL_PIX_W+5-1:5];

    always_comb begin
        width_x = CMP_W'(i_image_width);
        max_x   = CMP_W'(MAX_WIDTH);
        if (width_x < CMP_W'(3)) begin
            w_eff = CMP_W'(3);
        end else if (width_x > max_x) begin
            w_eff = max_x;
        end else begin
            w_eff = width_x;
        end
        h_eff = (i_image_height < 12'd3) ? 12'd3 : i_image_height;

        col   = i_start_of_frame ? '0 : r_col;
        row   = i_start_of_frame ? '0 : r_row;
        col_x = CMP_W'(col);

        o_col         = col;
        o_flags.emit  = (col_x >= CMP_W'(2)) && (row >= 12'd2) && (col_x < w_eff);
        o_flags.last  = (col_x == w_eff - CMP_W'(1)) && (row == h_eff - 12'd1);

        row_end = col_x >= w_eff - CMP_W'(1);
        if (row_end) begin
            n_col = '0;
            n_row = (row >= h_eff - 12'd1) ? '0 : row + 12'd1;
        end else begin
            n_col = col + COL_W'(1);
            n_row = row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// File: hw/rtl/sbl_queue.sv
// sbl_queue: two-entry queue between the front end and the back end
// depends on sbl_pkg only through its import, using nothing from it
`timescale 1ns / 1ps

module sbl_queue import sbl_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: hw/rtl/sbl_back.sv
// sbl_back: line stores, 3x3 window, sobel sums, squares and an iterative
// bit-pair square root feeding the output register; depends on sbl_pkg
`timescale 1ns / 1ps

module sbl_back import sbl_pkg::*; #(
    parameter int MAX_WIDTH = SBL_MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  logic [SBL_PIX_W-1:0]         i_gray,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  t_sbl_flags                   i_flags,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [SBL_GRAD_W-1:0] o_gradient_x,
    output logic signed [SBL_GRAD_W-1:0] o_gradient_y,
    output logic [SBL_MAG_W-1:0]         o_edge_magnitude,
    output logic                         o_frame_done
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } t_state;

    t_state r_state;

    logic [SBL_PIX_W-1:0] r_upper [MAX_WIDTH];
    logic [SBL_PIX_W-1:0] r_middle [MAX_WIDTH];
    logic [SBL_PIX_W-1:0] r_up_rd, r_mid_rd;

    logic [SBL_PIX_W-1:0] r_win [6];  // left column t/m/b, then centre column t/m/b
    logic [SBL_PIX_W-1:0] r_gray;
    logic [COL_W-1:0]     r_col;
    t_sbl_flags           r_flags;

    logic signed [SBL_GRAD_W-1:0] r_gx, r_gy;
    logic [19:0]                  r_sq_x, r_sq_y;
    logic [15:0]                  r_rad;
    logic [8:0]                   r_rem;
    logic [SBL_MAG_W-1:0]         r_root;
    logic [2:0]                   r_step;
    logic                         r_out_valid;

    logic [SBL_GRAD_W-1:0]        sum_l, sum_r, sum_t, sum_b;
    logic signed [2*SBL_GRAD_W-1:0] sq_x_full, sq_y_full;
    logic [20:0]                  sq_sum;
    logic [10:0]                  rem_sh, trial, rem_sub;
    logic                         take;
    logic                         out_free;

    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;

    // line stores: read when an item is taken, written back in the next cycle, in ST_READ
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_up_rd  <= r_upper[i_col];
            r_mid_rd <= r_middle[i_col];
        end
        if (r_state == ST_READ) begin
            r_upper[r_col]  <= r_mid_rd;
            r_middle[r_col] <= r_gray;
        end
    end

    always_comb begin
        // right column is top = upper store, mid = middle store, bottom = new gray
        sum_l = 11'(r_win[0]) + {2'b0, r_win[1], 1'b0} + 11'(r_win[2]);
        sum_r = 11'(r_up_rd) + {2'b0, r_mid_rd, 1'b0} + 11'(r_gray);
        sum_t = 11'(r_win[0]) + {2'b0, r_win[3], 1'b0} + 11'(r_up_rd);
        sum_b = 11'(r_win[2]) + {2'b0, r_win[5], 1'b0} + 11'(r_gray);

        sq_x_full = r_gx * r_gx;
        sq_y_full = r_gy * r_gy;
        sq_sum    = 21'(r_sq_x) + 21'(r_sq_y);

        rem_sh  = {r_rem, r_rad[15:14]};
        trial   = {1'b0, r_root, 2'b01};
        take    = rem_sh >= trial;
        rem_sub = rem_sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            // result register fills when an item finishes, empties when taken
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_gray  <= i_gray;
                        r_col   <= i_col;
                        r_flags <= i_flags;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_gx     <= $signed(sum_l - sum_r);
                    r_gy     <= $signed(sum_t - sum_b);
                    r_win[0] <= r_win[3];
                    r_win[1] <= r_win[4];
                    r_win[2] <= r_win[5];
                    r_win[3] <= r_up_rd;
                    r_win[4] <= r_mid_rd;
                    r_win[5] <= r_gray;
                    r_state  <= r_flags.emit ? ST_SQUARE : ST_IDLE;
                end
                ST_SQUARE: begin
                    r_sq_x  <= sq_x_full[19:0];
                    r_sq_y  <= sq_y_full[19:0];
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_rem  <= '0;
                    r_step <= 3'd7;
                    r_rad  <= sq_sum[15:0];
                    if (sq_sum[20:16] != 5'd0) begin
                        // saturate, root of 65536 or more
                        r_root  <= '1;
                        r_state <= ST_DONE;
                    end else begin
                        r_root  <= '0;
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    r_rad <= {r_rad[13:0], 2'b00};
                    if (take) begin
                        r_rem  <= rem_sub[8:0];
                        r_root <= {r_root[SBL_MAG_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh[8:0];
                        r_root <= {r_root[SBL_MAG_W-2:0], 1'b0};
                    end
                    r_step <= r_step - 3'd1;
                    if (r_step == 3'd0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        o_gradient_x     <= r_gx;
                        o_gradient_y     <= r_gy;
                        o_edge_magnitude <= r_root;
                        o_frame_done     <= r_flags.last;
                        r_state          <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/sobel_edge_3x3.sv
// sobel_edge_3x3: top level of the streaming 3x3 sobel edge detector, holds the
// configuration registers and joins front end, queue and back end; uses sbl_pkg
`timescale 1ns / 1ps

//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-------------------------------------
//  in      | to block  | i_in_valid / o_in_stall      | i_red i_green i_blue i_start_of_frame
//  out     | from block| o_out_valid / i_out_stall    | o_gradient_x o_gradient_y
//          |           |                              | o_edge_magnitude o_frame_done
//  cfg     | to block  | i_cfg_valid / o_cfg_ready    | i_cfg_index i_cfg_data
//
//  the front end takes one item per cycle into a two-entry queue while the queue
//  is not full; the back end takes one item at a time, a border pixel passing
//  through idle and read only, an interior pixel going on through square, sum,
//  the eight-step square root unit and done; a saturated magnitude skips the root
//  reset is synchronous and active low; line stores have no reset
//  o_in_stall is high while the queue is full; a stalled result waits in the
//  output register while the back end goes on with the next item up to its end

module sobel_edge_3x3 import sbl_pkg::*; #(
    parameter int MAX_WIDTH = SBL_MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // pixel input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [SBL_PIX_W-1:0]         i_red,
    input  logic [SBL_PIX_W-1:0]         i_green,
    input  logic [SBL_PIX_W-1:0]         i_blue,
    input  logic                         i_start_of_frame,
    // result output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [SBL_GRAD_W-1:0] o_gradient_x,
    output logic signed [SBL_GRAD_W-1:0] o_gradient_y,
    output logic [SBL_MAG_W-1:0]         o_edge_magnitude,
    output logic                         o_frame_done,
    // configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [SBL_CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [SBL_CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ENTRY_W = COL_W + SBL_PIX_W + $bits(t_sbl_flags);

    // configuration registers
    logic [SBL_WIDTH_W-1:0]  r_image_width;
    logic [SBL_HEIGHT_W-1:0] r_image_height;

    // front end to queue
    logic                    front_push;
    logic [SBL_PIX_W-1:0]    front_gray;
    logic [COL_W-1:0]        front_col;
    t_sbl_flags              front_flags;

    // queue to back end
    logic                    q_full, q_empty, q_pop;
    logic [ENTRY_W-1:0]      q_rdata;
    t_sbl_flags              back_flags;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= SBL_WIDTH_RST;
            r_image_height <= SBL_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                SBL_REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[SBL_WIDTH_W-1:0];
                SBL_REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // position tracking and classification, one item per cycle while the queue is not full
    sbl_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_start_of_frame(i_start_of_frame),
        .i_image_width   (r_image_width),
        .i_image_height  (r_image_height),
        .i_queue_full    (q_full),
        .o_push          (front_push),
        .o_gray          (front_gray),
        .o_col           (front_col),
        .o_flags         (front_flags)
    );

    // entry layout: column, gray, flags
    sbl_queue #(
        .DATA_W(ENTRY_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_push),
        .i_data ({front_col, front_gray, front_flags}),
        .i_pop  (q_pop),
        .o_data (q_rdata),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    assign back_flags = q_rdata[$bits(t_sbl_flags)-1:0];

    // line stores, window, gradients and root, one item at a time
    sbl_back #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_gray          (q_rdata[$bits(t_sbl_flags) +: SBL_PIX_W]),
        .i_col           (q_rdata[ENTRY_W-1 -: COL_W]),
        .i_flags         (back_flags),
        .o_pop           (q_pop),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_gradient_x    (o_gradient_x),
        .o_gradient_y    (o_gradient_y),
        .o_edge_magnitude(o_edge_magnitude),
        .o_frame_done    (o_frame_done)
    );

    // checks
    logic signed [2*SBL_GRAD_W-1:0] a_sq_x, a_sq_y;
    logic [20:0]                    a_grad_sq;
    logic [16:0]                    a_mag_lo, a_mag_hi;

    assign a_sq_x    = o_gradient_x * o_gradient_x;
    assign a_sq_y    = o_gradient_y * o_gradient_y;
    assign a_grad_sq = a_sq_x[20:0] + a_sq_y[20:0];
    assign a_mag_lo  = 17'(o_edge_magnitude) * 17'(o_edge_magnitude);
    assign a_mag_hi  = (17'(o_edge_magnitude) + 17'd1) * (17'(o_edge_magnitude) + 17'd1);

    // magnitude is the floor root of the shown gradients, or saturated
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (21'(a_mag_lo) <= a_grad_sq)
                     && (o_edge_magnitude == 8'd255 || 21'(a_mag_hi) > a_grad_sq))
        else $error("edge magnitude does not match gradients");

    // back end never takes from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

// File: sim/sobel_edge_3x3_tb.sv
// sobel_edge_3x3_tb: self-checking testbench for the streaming 3x3 sobel edge block
// drives rgb pixel items and register writes, predicts each gradient result and
// checks it as it leaves the block; depends on sbl_pkg and sobel_edge_3x3
`timescale 1ns / 1ps

module sobel_edge_3x3_tb;
    import sbl_pkg::*;

    // the limit covers a correct run of about 470 items through the back end, plus
    // sender gaps, receiver stalls and one long hold
    localparam int CYCLE_LIMIT  = 1_000_000;
    // drain margin covers two queued items plus the output register
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 100;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic signed [SBL_GRAD_W-1:0] grad_x;
        logic signed [SBL_GRAD_W-1:0] grad_y;
        logic [SBL_MAG_W-1:0]         magnitude;
        logic                         frame_end;
    } t_edge_result;

    typedef enum int {RX_FREE, RX_CHOPPY, RX_BURSTY} t_rx_mode;
    typedef enum int {PIX_NOISE, PIX_BINARY, PIX_SMOOTH, PIX_STRIPES} t_pix_style;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [SBL_PIX_W-1:0]         i_red;
    logic [SBL_PIX_W-1:0]         i_green;
    logic [SBL_PIX_W-1:0]         i_blue;
    logic                         i_start_of_frame;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic signed [SBL_GRAD_W-1:0] o_gradient_x;
    logic signed [SBL_GRAD_W-1:0] o_gradient_y;
    logic [SBL_MAG_W-1:0]         o_edge_magnitude;
    logic                         o_frame_done;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [SBL_CFG_IDX_W-1:0]     i_cfg_index;
    logic [SBL_CFG_DATA_W-1:0]    i_cfg_data;

    sobel_edge_3x3 u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_start_of_frame (i_start_of_frame),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_gradient_x     (o_gradient_x),
        .o_gradient_y     (o_gradient_y),
        .o_edge_magnitude (o_edge_magnitude),
        .o_frame_done     (o_frame_done),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor state: register copies, two line stores, window columns,
    // position of the next incoming pixel
    // ------------------------------------------------------------------
    logic [SBL_WIDTH_W-1:0]  cfg_width  = SBL_WIDTH_RST;
    logic [SBL_HEIGHT_W-1:0] cfg_height = SBL_HEIGHT_RST;
    bit [7:0]                line_two_up [SBL_MAX_WIDTH_DEF];
    bit [7:0]                line_one_up [SBL_MAX_WIDTH_DEF];
    int                      win_old [3];   // left window column, top/mid/bottom
    int                      win_ctr [3];   // centre window column
    int                      pix_col;
    int                      pix_row;

    t_edge_result            result_q [$];  // gradients still to come out
    int                      mismatch_cnt;
    int                      checked_cnt;

    // sender and receiver behavior, set by the tests
    bit                      tx_bursty;
    int                      burst_left;
    t_rx_mode                rx_mode;
    int                      long_hold_req;
    int                      long_hold_len;
    int                      cycle_cnt;

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit, counted in cycles
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // gray conversion, window update and sobel sums for one accepted pixel item
    task automatic predict_pixel(input logic [7:0] red, input logic [7:0] green,
                                 input logic [7:0] blue, input logic sof);
        int           w;
        int           h;
        int           c;
        int           r;
        int           luma;
        int           top;
        int           mid;
        int           gx;
        int           gy;
        int           sq;
        int           root;
        t_edge_result res;
        w = cfg_width;
        if (w < 3) w = 3;
        else if (w > SBL_MAX_WIDTH_DEF) w = SBL_MAX_WIDTH_DEF;
        h = cfg_height;
        if (h < 3) h = 3;
        luma = (11 * red + 16 * green + 5 * blue) >> 5;
        if (sof) begin
            pix_col = 0;
            pix_row = 0;
        end
        c   = pix_col;
        r   = pix_row;
        top = line_two_up[c];
        mid = line_one_up[c];

        // interior centre sits one row and one column behind the incoming pixel
        if (c >= 2 && r >= 2 && c < w) begin
            gx = (win_old[0] + 2 * win_old[1] + win_old[2]) - (top + 2 * mid + luma);
            gy = (win_old[0] + 2 * win_ctr[0] + top) - (win_old[2] + 2 * win_ctr[2] + luma);
            sq = gx * gx + gy * gy;
            // floor square root, stops at 255 so large sums saturate
            root = 0;
            while (root < 255 && (root + 1) * (root + 1) <= sq) root++;
            res.grad_x    = gx[SBL_GRAD_W-1:0];
            res.grad_y    = gy[SBL_GRAD_W-1:0];
            res.magnitude = root[SBL_MAG_W-1:0];
            res.frame_end = (c == w - 1 && r == h - 1);
            result_q.push_back(res);
        end

        win_old        = win_ctr;
        win_ctr[0]     = top;
        win_ctr[1]     = mid;
        win_ctr[2]     = luma;
        line_two_up[c] = 8'(mid);
        line_one_up[c] = 8'(luma);

        // a column or row at or past its limit wraps, so frames run on without sof
        if (c >= w - 1) begin
            pix_col = 0;
            pix_row = (r >= h - 1) ? 0 : r + 1;
        end else begin
            pix_col = c + 1;
        end
    endtask

    function automatic void note_failure(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX) $display("%s", msg);
    endfunction

    // result checker, samples at the rising edge
    always @(posedge i_clk) begin : result_check
        t_edge_result got;
        t_edge_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got = '{o_gradient_x, o_gradient_y, o_edge_magnitude, o_frame_done};
            if (result_q.size() == 0) begin
                note_failure($sformatf(
                    "result %0d with none expected: gx=%0d gy=%0d mag=%0d done=%0b",
                    checked_cnt, got.grad_x, got.grad_y, got.magnitude, got.frame_end));
            end else begin
                want = result_q.pop_front();
                if (got !== want) begin
                    note_failure({
                        $sformatf("result %0d: expected gx=%0d gy=%0d mag=%0d done=%0b",
                            checked_cnt, want.grad_x, want.grad_y, want.magnitude,
                            want.frame_end),
                        $sformatf(", got gx=%0d gy=%0d mag=%0d done=%0b",
                            got.grad_x, got.grad_y, got.magnitude, got.frame_end)});
                end
            end
            checked_cnt++;
        end
    end

    // receiver stall pattern, plus a long hold when a test asks for one
    initial begin : rx_stall_gen
        int  hold_seen;
        int  hold_left;
        int  run_left;
        bit  run_stall;
        i_out_stall = 1'b0;
        hold_seen   = 0;
        hold_left   = 0;
        run_left    = 0;
        run_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != long_hold_req) begin
                hold_seen = long_hold_req;
                hold_left = long_hold_len;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                case (rx_mode)
                    RX_FREE:   i_out_stall = 1'b0;
                    RX_CHOPPY: i_out_stall = ($urandom_range(0, 99) < 35);
                    default: begin
                        if (run_left == 0) begin
                            run_stall = ~run_stall;
                            run_left  = run_stall ? $urandom_range(1, 12) : $urandom_range(1, 20);
                        end
                        run_left--;
                        i_out_stall = run_stall;
                    end
                endcase
            end
        end
    end

    task automatic cfg_write(input logic [SBL_CFG_IDX_W-1:0] index,
                             input logic [SBL_CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        case (index)
            SBL_REG_IMAGE_WIDTH:  cfg_width  = data[SBL_WIDTH_W-1:0];
            SBL_REG_IMAGE_HEIGHT: cfg_height = data[SBL_HEIGHT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // offers one pixel item, with a random gap between bursts when enabled
    task automatic send_pixel(input logic [23:0] rgb, input logic sof);
        int gap;
        if (tx_bursty) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        @(negedge i_clk);
        i_in_valid       = 1'b1;
        i_red            = rgb[23:16];
        i_green          = rgb[15:8];
        i_blue           = rgb[7:0];
        i_start_of_frame = sof;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        predict_pixel(rgb[23:16], rgb[15:8], rgb[7:0], sof);
    endtask

    // lower valid, then wait for every expected result and the back end to settle
    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid       = 1'b0;
        i_start_of_frame = 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [23:0] gen_pixel(input t_pix_style style, input int col,
                                              input int row);
        logic [7:0] r8;
        logic [7:0] g8;
        logic [7:0] b8;
        case (style)
            PIX_NOISE: begin
                r8 = 8'($urandom_range(0, 255));
                g8 = 8'($urandom_range(0, 255));
                b8 = 8'($urandom_range(0, 255));
            end
            PIX_BINARY: begin
                r8 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                g8 = r8;
                b8 = r8;
            end
            PIX_SMOOTH: begin
                // gentle ramp, gives magnitudes below saturation
                r8 = 8'(col * 9 + row * 5 + $urandom_range(0, 6));
                g8 = r8;
                b8 = 8'(r8 + $urandom_range(0, 3));
            end
            default: begin
                r8 = (((col / 2) + (row / 3)) % 2) ? 8'($urandom_range(200, 255))
                                                   : 8'($urandom_range(0, 40));
                g8 = r8;
                b8 = r8;
            end
        endcase
        return {r8, g8, b8};
    endfunction

    task automatic send_pixels(input int cols, input int count, input t_pix_style style,
                               input bit sof_first);
        int n;
        for (n = 0; n < count; n++) begin
            send_pixel(gen_pixel(style, n % cols, n / cols), sof_first && n == 0);
        end
    endtask

    task automatic random_idling();
        tx_bursty  = ($urandom_range(0, 3) != 0);
        burst_left = 0;
        rx_mode    = t_rx_mode'($urandom_range(0, 2));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // register reset values: at the 640 wide default a short burst stays in
    // row 0 and gives no result
    task automatic test_reset_sizes();
        random_idling();
        send_pixels(640, 40, PIX_NOISE, 1'b1);
        wait_drain();
    endtask

    // hand-picked 3 wide frame: flat, full-scale gradients both signs, pure colors
    task automatic test_directed_extremes();
        logic [23:0] pix [24];
        int          n;
        pix = '{24'h000000, 24'h000000, 24'h000000,
                24'h000000, 24'h000000, 24'h000000,
                24'h000000, 24'h000000, 24'h000000,
                24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                24'h000000, 24'h000000, 24'hFFFFFF,
                24'h000000, 24'h000000, 24'hFFFFFF,
                24'h000000, 24'h000000, 24'hFFFFFF,
                24'hFF0000, 24'h00FF00, 24'h0000FF};
        cfg_write(SBL_REG_IMAGE_WIDTH, 12'd3);
        cfg_write(SBL_REG_IMAGE_HEIGHT, 12'd8);
        tx_bursty = 1'b0;
        rx_mode   = RX_FREE;
        for (n = 0; n < 24; n++) send_pixel(pix[n], n == 0);
        wait_drain();
    endtask

    // out of range widths and heights clamp, width takes only its low data bits
    task automatic test_register_clamp();
        random_idling();
        cfg_write(SBL_REG_IMAGE_WIDTH, 12'd0);
        cfg_write(SBL_REG_IMAGE_HEIGHT, 12'd0);
        send_pixels(3, 18, PIX_NOISE, 1'b1);
        wait_drain();
        cfg_write(SBL_REG_IMAGE_WIDTH, 12'h803);
        cfg_write(SBL_REG_IMAGE_HEIGHT, 12'd2);
        send_pixels(3, 9, PIX_BINARY, 1'b1);
        wait_drain();
        // widest line: 2047 clamps to the full line store, first row gives nothing
        cfg_write(SBL_REG_IMAGE_WIDTH, 12'h7FF);
        cfg_write(SBL_REG_IMAGE_HEIGHT, 12'd1);
        send_pixels(SBL_MAX_WIDTH_DEF, 40, PIX_NOISE, 1'b1);
        wait_drain();
    endtask

    // frames back to back without sof, sof in mid frame, counters past a shrunk size
    task automatic test_wrap_and_resync();
        random_idling();
        cfg_write(SBL_REG_IMAGE_WIDTH, 12'd10);
        cfg_write(SBL_REG_IMAGE_HEIGHT, 12'd5);
        send_pixels(10, 50, PIX_NOISE, 1'b1);
        // next frame runs on without sof and is cut inside row 2
        send_pixels(10, 24, PIX_BINARY, 1'b0);
        // sof in mid frame, stop at row 3 column 7
        send_pixels(10, 37, PIX_STRIPES, 1'b1);
        wait_drain();
        // column 7 and row 3 are now past the limits and must wrap
        cfg_write(SBL_REG_IMAGE_WIDTH, 12'd4);
        cfg_write(SBL_REG_IMAGE_HEIGHT, 12'd3);
        send_pixels(4, 1, PIX_NOISE, 1'b0);
        send_pixels(4, 24, PIX_NOISE, 1'b0);
        wait_drain();
    endtask

    // tallest frame setting, only a slice of it is sent
    task automatic test_tall_frame();
        random_idling();
        cfg_write(SBL_REG_IMAGE_WIDTH, 12'd3);
        cfg_write(SBL_REG_IMAGE_HEIGHT, 12'd4095);
        send_pixels(3, 3 * 16, PIX_SMOOTH, 1'b1);
        wait_drain();
    endtask

    // receiver holds off for a long stretch while items keep coming, input must stall
    task automatic test_input_backpressure();
        cfg_write(SBL_REG_IMAGE_WIDTH, 12'd6);
        cfg_write(SBL_REG_IMAGE_HEIGHT, 12'd4);
        tx_bursty     = 1'b0;
        rx_mode       = RX_FREE;
        long_hold_len = 300;
        long_hold_req++;
        send_pixels(6, 48, PIX_NOISE, 1'b1);
        wait_drain();
    endtask

    // random sizes and contents, frames cut short and stray sof as noise
    task automatic test_random_frames();
        int         w;
        int         h;
        int         frames;
        int         f;
        int         cut;
        int         n;
        int         sent;
        bit         restart;
        bit         sof;
        t_pix_style style;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(3, 10);
            h = $urandom_range(3, 5);
            cfg_write(SBL_REG_IMAGE_WIDTH, SBL_CFG_DATA_W'(w));
            cfg_write(SBL_REG_IMAGE_HEIGHT, SBL_CFG_DATA_W'(h));
            random_idling();
            frames  = $urandom_range(1, 3);
            restart = 1'b1;
            for (f = 0; f < frames && sent < RANDOM_ITEMS; f++) begin
                style = t_pix_style'($urandom_range(0, 3));
                cut   = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w * h - 1) : w * h;
                if (cut > RANDOM_ITEMS - sent) cut = RANDOM_ITEMS - sent;
                for (n = 0; n < cut; n++) begin
                    sof = (n == 0 && (restart || $urandom_range(0, 1))) ||
                          ($urandom_range(0, 79) == 0);
                    send_pixel(gen_pixel(style, n % w, n / w), sof);
                end
                sent   += cut;
                // a frame cut short is followed by a fresh sof
                restart = (cut != w * h);
            end
            wait_drain();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_red            = '0;
        i_green          = '0;
        i_blue           = '0;
        i_start_of_frame = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = SBL_REG_IMAGE_WIDTH;
        i_cfg_data       = '0;
        tx_bursty        = 1'b0;
        burst_left       = 0;
        rx_mode          = RX_FREE;
        long_hold_req    = 0;
        long_hold_len    = 0;
        mismatch_cnt     = 0;
        checked_cnt      = 0;
        pix_col          = 0;
        pix_row          = 0;
        win_old          = '{0, 0, 0};
        win_ctr          = '{0, 0, 0};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_sizes();
        test_directed_extremes();
        test_register_clamp();
        test_wrap_and_resync();
        test_tall_frame();
        test_input_backpressure();
        test_random_frames();

        wait_drain();
        if (mismatch_cnt == 0 && result_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
